// File: sv/sll_pkg.sv
package sll_pkg;

	localparam int POS_W    = 7;
	localparam int LEN_W    = 7;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_DELETE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		status_t            status;
		logic [LEN_W-1:0]   length;
	} res_t;

endpackage

// File: sv/sll_link_ram.sv
module sll_link_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 7
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// File: sv/sll_seq.sv
module sll_seq import sll_pkg::*; #(
	parameter int SLOTS = 128
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic                       cmd,
	input  logic [POS_W-1:0]           position,
	input  logic signed [VAL_W-1:0]    value,
	output logic                       link_wr_en,
	output logic [$clog2(SLOTS)-1:0]   link_wr_addr,
	output logic [$clog2(SLOTS)-1:0]   link_wr_data,
	output logic [$clog2(SLOTS)-1:0]   link_rd_addr,
	input  logic [$clog2(SLOTS)-1:0]   link_rd_data,
	output logic                       res_valid,
	output res_t                       res,
	input  logic                       res_stall
);

	localparam int LINK_W = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(SLOTS - 1);
	localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
	localparam logic [LINK_W-1:0] FREE_HEAD = '0;
	localparam logic [LINK_W-1:0] USED_HEAD = LINK_W'(SLOTS - 1);
	localparam logic [LINK_W-1:0] LAST_FREE = LINK_W'(SLOTS - 2);

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_INS_FREE,
		S_INS_POP,
		S_WALK,
		S_INS_LINK,
		S_INS_HOOK,
		S_DEL_VICT,
		S_DEL_UNL,
		S_DEL_FREE,
		S_DEL_PUSH,
		S_DONE
	} state_t;

	state_t                   state_q;
	logic [LINK_W-1:0]        init_q;
	logic [CNT_W-1:0]         count_q;
	logic                     cmd_q;
	logic signed [VAL_W-1:0]  val_q;
	logic [POS_W-1:0]         remain_q;
	logic [LINK_W-1:0]        k_q;
	logic                     first_q;
	logic [LINK_W-1:0]        pred_q;
	logic [LINK_W-1:0]        slot_q;
	status_t                  res_status_q;

	logic signed [VAL_W-1:0]  element_store [SLOTS];

	logic [LINK_W-1:0]        k_cur;
	logic [CMP_W-1:0]         pos_w;
	logic [CMP_W-1:0]         cnt_w;
	logic                     pos_bad;
	logic                     rd_bad;

	assign k_cur   = first_q ? k_q : link_rd_data;
	assign pos_w   = CMP_W'(position);
	assign cnt_w   = CMP_W'(count_q);
	assign pos_bad = (position == '0) ||
		((cmd == CMD_INSERT) ? (pos_w > cnt_w + CMP_W'(1)) : (pos_w > cnt_w));
	assign rd_bad  = (link_rd_data == FREE_HEAD) || (link_rd_data >= USED_HEAD);

	assign req_stall  = (state_q != S_IDLE);
	assign res_valid  = (state_q == S_DONE);
	assign res.status = res_status_q;
	assign res.length = LEN_W'(count_q);

	always_comb begin
		link_wr_en   = 1'b0;
		link_wr_addr = FREE_HEAD;
		link_wr_data = FREE_HEAD;
		link_rd_addr = k_cur;
		case (state_q)
			S_INIT: begin
				link_wr_en   = 1'b1;
				link_wr_addr = init_q;
				link_wr_data = (init_q < LAST_FREE) ? init_q + LINK_W'(1) : FREE_HEAD;
			end
			S_IDLE: begin
				link_rd_addr = FREE_HEAD;
			end
			S_INS_FREE: begin
				link_rd_addr = link_rd_data;
			end
			S_INS_POP: begin
				link_wr_en   = 1'b1;
				link_wr_addr = FREE_HEAD;
				link_wr_data = link_rd_data;
			end
			S_INS_LINK: begin
				link_wr_en   = 1'b1;
				link_wr_addr = slot_q;
				link_wr_data = link_rd_data;
			end
			S_INS_HOOK: begin
				link_wr_en   = 1'b1;
				link_wr_addr = pred_q;
				link_wr_data = slot_q;
			end
			S_DEL_VICT: begin
				link_rd_addr = link_rd_data;
			end
			S_DEL_UNL: begin
				link_wr_en   = 1'b1;
				link_wr_addr = pred_q;
				link_wr_data = link_rd_data;
				link_rd_addr = FREE_HEAD;
			end
			S_DEL_FREE: begin
				link_wr_en   = 1'b1;
				link_wr_addr = slot_q;
				link_wr_data = link_rd_data;
			end
			S_DEL_PUSH: begin
				link_wr_en   = 1'b1;
				link_wr_addr = FREE_HEAD;
				link_wr_data = slot_q;
			end
			default: begin
				link_rd_addr = k_cur;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_INS_POP) begin
			element_store[slot_q] <= val_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			init_q       <= '0;
			count_q      <= '0;
			cmd_q        <= CMD_INSERT;
			val_q        <= '0;
			remain_q     <= '0;
			k_q          <= USED_HEAD;
			first_q      <= 1'b1;
			pred_q       <= '0;
			slot_q       <= '0;
			res_status_q <= STAT_OK;
		end else begin
			case (state_q)
				S_INIT: begin
					init_q <= init_q + LINK_W'(1);
					if (init_q == USED_HEAD) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						cmd_q    <= cmd;
						val_q    <= value;
						remain_q <= position - POS_W'(1);
						k_q      <= USED_HEAD;
						first_q  <= 1'b1;
						if (pos_bad) begin
							res_status_q <= STAT_RANGE;
							state_q      <= S_DONE;
						end else if (cmd == CMD_INSERT) begin
							state_q <= S_INS_FREE;
						end else begin
							state_q <= S_WALK;
						end
					end
				end
				S_INS_FREE: begin
					if (rd_bad) begin
						res_status_q <= STAT_FULL;
						state_q      <= S_DONE;
					end else begin
						slot_q  <= link_rd_data;
						state_q <= S_INS_POP;
					end
				end
				S_INS_POP: begin
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (remain_q == '0) begin
						pred_q  <= k_cur;
						state_q <= (cmd_q == CMD_INSERT) ? S_INS_LINK : S_DEL_VICT;
					end else begin
						remain_q <= remain_q - POS_W'(1);
						first_q  <= 1'b0;
					end
				end
				S_INS_LINK: begin
					state_q <= S_INS_HOOK;
				end
				S_INS_HOOK: begin
					count_q      <= count_q + CNT_W'(1);
					res_status_q <= STAT_OK;
					state_q      <= S_DONE;
				end
				S_DEL_VICT: begin
					if (rd_bad) begin
						res_status_q <= STAT_RANGE;
						state_q      <= S_DONE;
					end else begin
						slot_q  <= link_rd_data;
						state_q <= S_DEL_UNL;
					end
				end
				S_DEL_UNL: begin
					state_q <= S_DEL_FREE;
				end
				S_DEL_FREE: begin
					state_q <= S_DEL_PUSH;
				end
				S_DEL_PUSH: begin
					count_q      <= count_q - CNT_W'(1);
					res_status_q <= STAT_OK;
					state_q      <= S_DONE;
				end
				S_DONE: begin
					if (!res_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: sv/static_linked_list_engine_unit.sv
// linked list of signed 32-bit values kept in a fixed slot array
// request channel: req_valid / req_stall with cmd, position, value
//   cmd insert puts value at 1-based position, cmd delete removes that element
// response channel: rsp_valid / rsp_stall with status and length
//   status ok, position out of range, or no free slot; length after the request
// one request is worked on at a time; a good request, one with a valid position
// and, for an insert, a free slot, walks the link memory from the list head to
// the predecessor, one link read per cycle through a simple dual-port ram; a bad
// position or a full list is answered without the walk
// the next request is taken once the response sits in the output register
// a response held by rsp_stall stays put; a new request is still taken and
// worked on, and its response waits until the output register frees up
// after reset the link memory is chained into the free list, during which
// req_stall stays high; the list is then empty
module static_linked_list_engine_unit import sll_pkg::*; #(
	parameter int SLOTS = 128
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  logic                    cmd,
	input  logic [POS_W-1:0]        position,
	input  logic signed [VAL_W-1:0] value,
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output logic [STATUS_W-1:0]     status,
	output logic [LEN_W-1:0]        length
);

	localparam int LINK_W = $clog2(SLOTS);

	logic              link_wr_en;
	logic [LINK_W-1:0] link_wr_addr;
	logic [LINK_W-1:0] link_wr_data;
	logic [LINK_W-1:0] link_rd_addr;
	logic [LINK_W-1:0] link_rd_data;
	logic              res_valid;
	logic              res_stall;
	res_t              res;
	res_t              out_q;
	logic              out_valid_q;

	sll_link_ram #(
		.DEPTH (SLOTS),
		.WIDTH (LINK_W)
	) u_link_ram (
		.clk     (clk),
		.wr_en   (link_wr_en),
		.wr_addr (link_wr_addr),
		.wr_data (link_wr_data),
		.rd_addr (link_rd_addr),
		.rd_data (link_rd_data)
	);

	sll_seq #(
		.SLOTS (SLOTS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.cmd          (cmd),
		.position     (position),
		.value        (value),
		.link_wr_en   (link_wr_en),
		.link_wr_addr (link_wr_addr),
		.link_wr_data (link_wr_data),
		.link_rd_addr (link_rd_addr),
		.link_rd_data (link_rd_data),
		.res_valid    (res_valid),
		.res          (res),
		.res_stall    (res_stall)
	);

	assign res_stall = out_valid_q && rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (res_valid && !res_stall) begin
				out_valid_q <= 1'b1;
				out_q       <= res;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign status    = out_q.status;
	assign length    = out_q.length;

endmodule

// File: sv/sll_checker.sv
module sll_checker import sll_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    req_valid,
	input logic                    req_stall,
	input logic                    rsp_valid,
	input logic                    rsp_stall,
	input logic [STATUS_W-1:0]     status,
	input logic [LEN_W-1:0]        length
);

	logic req_acc;

	assign req_acc = req_valid && !req_stall;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(length))
		else $error("held response changed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (status == STAT_OK || status == STAT_RANGE || status == STAT_FULL))
		else $error("unknown status code");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> req_stall)
		else $error("second request taken while one is in progress");

	a_no_instant_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !$rose(rsp_valid))
		else $error("response appeared too early");

	a_length_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == STAT_FULL |-> length != '0)
		else $error("no free slot reported on an empty list");

endmodule

bind static_linked_list_engine_unit sll_checker u_sll_checker (.*);
